// File: hdl/pbsb_pkg.sv
// shared types, constants and helpers for the page buffer sprite blitter
`timescale 1ns / 1ps
package pbsb_pkg;

   localparam int COLUMNS     = 128;
   localparam int PAGES       = 4;
   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int SCREEN_ROWS = 8 * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int PG_W        = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam logic signed [10:0] COL_LIM  = 11'(COLUMNS);
   localparam logic signed [10:0] ROW_LIM  = 11'(SCREEN_ROWS);
   localparam logic signed [11:0] PAGE_LIM = 12'(PAGES);
   localparam logic [7:0]         BYTE_ONES = 8'hFF;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_LO_RD,
      ST_LO_WR,
      ST_HI_RD,
      ST_HI_WR,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [PG_W-1:0] pg,
                                                 input logic [COL_W-1:0] cl);
      return ADDR_W'(int'(pg) * COLUMNS + int'(cl));
   endfunction

endpackage

// File: hdl/page_buffer_sprite_blitter.sv
// start, and a sprite byte with no active sprite, complete without raising busy; other sprite bytes take
// an address calc plus a read and a write for each of up to two destination pages
// read: result strobe in the cycle after the transaction, with busy high while it is shown
// clear: one store byte per cycle, zeroing all STORE_BYTES bytes (512 by default) with busy high
// reset: sprite state cleared, then a zeroing pass over the whole store with busy high
// results cannot be stalled; rsp_valid is a single-cycle strobe
`timescale 1ns / 1ps
module page_buffer_sprite_blitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [7:0]        req_sprite_width,
   input  logic [7:0]        req_sprite_height,
   input  logic [7:0]        req_pic_byte,
   input  logic [8:0]        req_read_address,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data,
   output logic [8:0]        rsp_read_index
);
   import pbsb_pkg::*;

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   pbsb_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .req_pic_byte      (req_pic_byte),
      .req_read_address  (req_read_address),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_index    (rsp_read_index),
      .mem_req           (mem_req),
      .mem_rdata         (mem_rdata)
   );

   pbsb_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

// File: hdl/pbsb_store.sv
// framebuffer memory, one write port and one registered read port
`timescale 1ns / 1ps
module pbsb_store (
   input  logic                      clock,
   input  pbsb_pkg::mem_req_type     mem_req,
   output logic [7:0]                rdata
);
   import pbsb_pkg::*;

   logic [7:0] frame_mem [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         frame_mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= frame_mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/pbsb_seq.sv
// sequencer with shared read-modify-write merge unit and sprite state
`timescale 1ns / 1ps
module pbsb_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic signed [8:0]             req_pos_x,
   input  logic signed [8:0]             req_pos_y,
   input  logic [7:0]                    req_sprite_width,
   input  logic [7:0]                    req_sprite_height,
   input  logic [7:0]                    req_pic_byte,
   input  logic [8:0]                    req_read_address,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_read_data,
   output logic [8:0]                    rsp_read_index,
   output pbsb_pkg::mem_req_type         mem_req,
   input  logic [7:0]                    mem_rdata
);
   import pbsb_pkg::*;

   state_type state_ff, state_in;
   action_type act;
   logic accept;

   // sprite control state
   logic signed [8:0] blit_x_ff, blit_y_ff;
   logic [7:0]        width_ff, height_ff, colcnt_ff;
   logic [5:0]        pagecnt_ff;
   logic              active_ff;
   logic [ADDR_W-1:0] clr_ff;

   // per-byte datapath registers
   logic [7:0]        pic_ff;
   logic [15:0]       data_ff, mask_ff;
   logic [ADDR_W-1:0] lo_addr_ff, hi_addr_ff;
   logic              hi_ok_ff;
   logic [8:0]        rd_idx_ff;
   logic              rd_ok_ff;

   // start window check
   logic signed [10:0] sx, sy, sw, sh;
   logic               start_active;

   // byte placement
   logic signed [10:0] col, remain;
   logic signed [11:0] row0, pg0, pg1;
   logic               col_ok, lo_ok, hi_ok;
   logic [7:0]         keep8;
   logic [15:0]        data16, mask16;
   logic [8:0]         col_next;
   logic [6:0]         page_next;
   logic [5:0]         pages_total;

   // merge unit
   logic [7:0] m_data, m_mask, merged;

   assign act    = action_type'(req_action);
   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      sx = {{2{req_pos_x[8]}}, req_pos_x};
      sy = {{2{req_pos_y[8]}}, req_pos_y};
      sw = {3'b000, req_sprite_width};
      sh = {3'b000, req_sprite_height};
      start_active = (req_sprite_width != 8'd0) && (req_sprite_height != 8'd0) &&
                     (sx < COL_LIM) && (sx + sw > 11'sd0) &&
                     (sy < ROW_LIM) && (sy + sh > 11'sd0);
   end

   always_comb begin
      col    = {{2{blit_x_ff[8]}}, blit_x_ff} + {3'b000, colcnt_ff};
      col_ok = (col >= 11'sd0) && (col < COL_LIM);
      row0   = {{3{blit_y_ff[8]}}, blit_y_ff} + {3'b000, pagecnt_ff, 3'b000};
      pg0    = row0 >>> 3;
      pg1    = pg0 + 12'sd1;
      remain = {3'b000, height_ff} - {2'b00, pagecnt_ff, 3'b000};
      for (int b = 0; b < 8; b++) begin
         keep8[b] = remain > 11'(b);
      end
      data16 = {8'h00, pic_ff} << blit_y_ff[2:0];
      mask16 = {8'h00, keep8} << blit_y_ff[2:0];
      lo_ok  = col_ok && (pg0 >= 12'sd0) && (pg0 < PAGE_LIM) && (mask16[7:0] != 8'h00);
      hi_ok  = col_ok && (pg1 >= 12'sd0) && (pg1 < PAGE_LIM) && (mask16[15:8] != 8'h00);
      col_next    = {1'b0, colcnt_ff} + 9'd1;
      page_next   = {1'b0, pagecnt_ff} + 7'd1;
      pages_total = 6'(({1'b0, height_ff} + 9'd7) >> 3);
   end

   // shared merge: sprite bits replace covered pixels
   always_comb begin
      m_data = (state_ff == ST_HI_WR) ? data_ff[15:8] : data_ff[7:0];
      m_mask = (state_ff == ST_HI_WR) ? mask_ff[15:8] : mask_ff[7:0];
      merged = (mem_rdata & (m_mask ^ BYTE_ONES)) | (m_data & m_mask);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(STORE_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               unique case (act)
                  ACT_START: state_in = ST_IDLE;
                  ACT_BYTE:  state_in = active_ff ? ST_CALC : ST_IDLE;
                  ACT_READ:  state_in = ST_READ_OUT;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CALC: begin
            priority if (lo_ok) state_in = ST_LO_RD;
            else if (hi_ok)     state_in = ST_HI_RD;
            else                state_in = ST_IDLE;
         end
         ST_LO_RD:    state_in = ST_LO_WR;
         ST_LO_WR:    state_in = hi_ok_ff ? ST_HI_RD : ST_IDLE;
         ST_HI_RD:    state_in = ST_HI_WR;
         ST_HI_WR:    state_in = ST_IDLE;
         ST_READ_OUT: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = state_ff != ST_IDLE;
      rsp_valid     = state_ff == ST_READ_OUT;
      rsp_read_data = rd_ok_ff ? mem_rdata : 8'h00;
      rsp_read_index = rd_idx_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = lo_addr_ff;
      mem_req.wdata = merged;
      mem_req.raddr = ADDR_W'(req_read_address);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = 8'h00;
         end
         ST_LO_RD: mem_req.raddr = lo_addr_ff;
         ST_LO_WR: mem_req.we    = 1'b1;
         ST_HI_RD: mem_req.raddr = hi_addr_ff;
         ST_HI_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_addr_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         blit_x_ff  <= '0;
         blit_y_ff  <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         colcnt_ff  <= '0;
         pagecnt_ff <= '0;
         active_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (accept && act == ACT_CLEAR) begin
            clr_ff <= '0;
         end
         if (accept && act == ACT_START) begin
            blit_x_ff  <= req_pos_x;
            blit_y_ff  <= req_pos_y;
            width_ff   <= req_sprite_width;
            height_ff  <= req_sprite_height;
            colcnt_ff  <= '0;
            pagecnt_ff <= '0;
            active_ff  <= start_active;
         end
         if (state_ff == ST_CALC) begin
            if (col_next >= {1'b0, width_ff}) begin
               colcnt_ff  <= '0;
               pagecnt_ff <= page_next[5:0];
               if (page_next >= {1'b0, pages_total}) active_ff <= 1'b0;
            end else begin
               colcnt_ff <= col_next[7:0];
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && act == ACT_BYTE) begin
         pic_ff <= req_pic_byte;
      end
      if (accept && act == ACT_READ) begin
         rd_idx_ff <= req_read_address;
         rd_ok_ff  <= 32'(req_read_address) < STORE_BYTES;
      end
      if (state_ff == ST_CALC) begin
         data_ff    <= data16;
         mask_ff    <= mask16;
         hi_ok_ff   <= hi_ok;
         lo_addr_ff <= addr_of(pg0[PG_W-1:0], col[COL_W-1:0]);
         hi_addr_ff <= addr_of(pg1[PG_W-1:0], col[COL_W-1:0]);
      end
   end

endmodule

// File: hdl/pbsb_checker.sv
// port-level checks for the sprite blitter, bound to the top level
`timescale 1ns / 1ps
module pbsb_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_action,
   input logic [8:0] req_read_address,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data,
   input logic [8:0] rsp_read_index
);
   import pbsb_pkg::*;

   logic acc_read, acc_clear;
   assign acc_read  = start && !busy && (req_action == ACT_READ);
   assign acc_clear = start && !busy && (req_action == ACT_CLEAR);

   // a read transaction gives its strobe on the next cycle
   a_read_strobe: assert property (@(posedge clock) disable iff (reset)
      acc_read |=> rsp_valid && busy)
      else $error("read transaction without result strobe");

   // no result appears without a read transaction just before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc_read))
      else $error("result strobe without read transaction");

   a_index_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_index == $past(req_read_address))
      else $error("read index does not echo the address");

   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_read_index) >= STORE_BYTES)) |-> rsp_read_data == 8'h00)
      else $error("out of range read returned nonzero data");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      acc_clear |=> busy)
      else $error("clear transaction did not hold busy");

endmodule

bind page_buffer_sprite_blitter pbsb_checker u_pbsb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .req_read_address (req_read_address),
   .rsp_valid        (rsp_valid),
   .rsp_read_data    (rsp_read_data),
   .rsp_read_index   (rsp_read_index)
);
